// ===== sv/sls_pkg.sv =====
`default_nettype none
package sls_pkg;

	// Line offset between the scan line and the stored y byte
	localparam int unsigned LINE_OFFSET  = 16;
	localparam int unsigned SHORT_HEIGHT = 8;
	localparam int unsigned TALL_HEIGHT  = 16;

	// One attribute table entry as it arrives
	typedef struct packed {
		logic [5:0] entry_index;
		logic [7:0] line;
		logic [7:0] pos_y;
		logic [7:0] pos_x;
		logic [7:0] tile_number;
		logic [7:0] attributes;
	} sls_entry_t;

	// One item of the emitted list
	typedef struct packed {
		logic       found;
		logic [3:0] slot;
		logic [7:0] out_y;
		logic [7:0] out_x;
		logic [7:0] out_tile;
		logic [7:0] out_attributes;
		logic       last_of_run;
	} sls_result_t;

	// Stored sprite in the sorted list
	typedef struct packed {
		logic [7:0] y;
		logic [7:0] x;
		logic [7:0] tile;
		logic [7:0] attr;
	} sls_sprite_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic eval;
		logic load;
	} sls_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic eval_last;
		logic out_free;
		logic emit_last;
	} sls_stat_t;

endpackage
`default_nettype wire

// ===== sv/sls_stream_if.sv =====
`default_nettype none
interface sls_entry_if;
	logic               valid;
	logic               ready;
	sls_pkg::sls_entry_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sls_result_if;
	logic                valid;
	logic                ready;
	sls_pkg::sls_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/sls_ctrl.sv =====
`default_nettype none
module sls_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire sls_pkg::sls_stat_t stat,
	output sls_pkg::sls_cmd_t    cmd
);
	import sls_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EVAL = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Decode commands and next state
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.eval    = 1'b0;
		cmd.load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = stat.eval_last ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				cmd.load = stat.out_free;
				if (stat.out_free && stat.emit_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

// ===== sv/sls_datapath.sv =====
`default_nettype none
module sls_datapath #(
	parameter int MAX_CHOSEN    = 10,
	parameter int TABLE_ENTRIES = 40
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_wdata,
	input  wire sls_pkg::sls_entry_t in_data,
	input  wire sls_pkg::sls_cmd_t   cmd,
	output sls_pkg::sls_stat_t    stat,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output sls_pkg::sls_result_t  out_data
);
	import sls_pkg::*;

	localparam int CNT_W  = $clog2(MAX_CHOSEN + 1);
	localparam int EMIT_W = (MAX_CHOSEN > 1) ? $clog2(MAX_CHOSEN) : 1;

	logic                tall_q;
	sls_entry_t          in_q;
	sls_sprite_t         list_q [MAX_CHOSEN];
	logic [CNT_W-1:0]    count_q;
	logic [EMIT_W-1:0]   emit_q;
	logic                out_valid_q;
	sls_result_t         out_q;

	logic                idx_ok, is_first, is_last, hit;
	logic [CNT_W-1:0]    cnt_eff;
	logic [8:0]          target, bottom;
	logic [MAX_CHOSEN-1:0] le;
	sls_sprite_t         new_spr;
	sls_sprite_t         rd_spr;
	logic                emit_last;

	// Hold the height select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tall_q <= 1'b0;
		else if (cfg_we) tall_q <= cfg_wdata;
	end

	// Capture the accepted entry
	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= in_data;
	end

	// Evaluate line coverage and list capacity
	always_comb begin
		idx_ok   = {1'b0, in_q.entry_index} < 7'(TABLE_ENTRIES);
		is_first = in_q.entry_index == 6'd0;
		is_last  = {1'b0, in_q.entry_index} == 7'(TABLE_ENTRIES - 1);
		cnt_eff  = is_first ? '0 : count_q;
		target   = {1'b0, in_q.line} + 9'(LINE_OFFSET);
		bottom   = {1'b0, in_q.pos_y} + (tall_q ? 9'(TALL_HEIGHT) : 9'(SHORT_HEIGHT));
		hit      = ({1'b0, in_q.pos_y} <= target) && (bottom > target)
			&& (cnt_eff < CNT_W'(MAX_CHOSEN));
		new_spr  = '{y: in_q.pos_y, x: in_q.pos_x, tile: in_q.tile_number,
			attr: in_q.attributes};
		for (int k = 0; k < MAX_CHOSEN; k++) begin
			le[k] = (CNT_W'(k) < cnt_eff) && (list_q[k].x <= in_q.pos_x);
		end
	end

	// Insert into the sorted list: keep the prefix, drop in, shift the rest
	for (genvar k = 0; k < MAX_CHOSEN; k++) begin : g_slot
		if (k == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (cmd.eval && idx_ok && hit && !le[k]) list_q[k] <= new_spr;
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (cmd.eval && idx_ok && hit && !le[k])
					list_q[k] <= le[k-1] ? new_spr : list_q[k-1];
			end
		end
	end

	// Track the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cmd.eval && idx_ok) count_q <= cnt_eff + CNT_W'(hit);
	end

	// Walk the list during emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) emit_q <= '0;
		else if (cmd.eval) emit_q <= '0;
		else if (cmd.load) emit_q <= emit_q + 1'b1;
	end

	assign rd_spr    = list_q[emit_q];
	assign emit_last = (count_q == '0) || (CNT_W'(emit_q) + 1'b1 == count_q);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (count_q == '0) begin
				out_q <= '{found: 1'b0, slot: 4'd0, out_y: 8'd0, out_x: 8'd0,
					out_tile: 8'd0, out_attributes: 8'd0, last_of_run: 1'b1};
			end else begin
				out_q.found          <= 1'b1;
				out_q.slot           <= 4'(emit_q);
				out_q.out_y          <= rd_spr.y;
				out_q.out_x          <= rd_spr.x;
				out_q.out_tile       <= rd_spr.tile;
				out_q.out_attributes <= rd_spr.attr;
				out_q.last_of_run    <= emit_last;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_data       = out_q;
	assign stat.eval_last = idx_ok && is_last;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.emit_last = emit_last;

endmodule
`default_nettype wire

// ===== sv/sprite_line_scan_sorted.sv =====
`default_nettype none
// Channel    Dir   Payload         Handshake
// entry      in    sls_entry_t     valid/ready, taken on valid & ready
// result     out   sls_result_t    valid/ready, taken on valid & ready
// cfg        in    tall_sprites    cfg_we strobe, cfg_wdata
//
// Each entry is captured, then compared in parallel and inserted into
// the sorted register list; no new entry is taken meanwhile.
// The last table index then emits max(1, kept) results, one per cycle
// while result is taken; the output register frees the far side. Reset
// clears control state, fill and emit counts, valid and height select.
module sprite_line_scan_sorted #(
	parameter int MAX_CHOSEN    = 10,
	parameter int TABLE_ENTRIES = 40
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	sls_entry_if.sink   entry,
	sls_result_if.source result
);
	import sls_pkg::*;

	sls_cmd_t  cmd;
	sls_stat_t stat;

	// Sequence capture, evaluation and emission
	sls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (entry.valid),
		.in_ready (entry.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold the sorted list and the output register
	sls_datapath #(
		.MAX_CHOSEN    (MAX_CHOSEN),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (entry.data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result.data)
	);

endmodule
`default_nettype wire
